>>> design/ief_pkg.sv
// shared types, widths and coefficient tables for the inverse error function pipeline
`default_nettype none
package ief_pkg;

	localparam int X_W     = 32;
	localparam int XS_W    = 31;
	localparam int D_W     = 61;
	localparam int NORM_W  = 64;
	localparam int LZ_W    = 6;
	localparam int M_W     = 32;
	localparam int FRAC_W  = 30;
	localparam int L_W     = 36;
	localparam int LN2_W   = 28;
	localparam int W_W     = 36;
	localparam int SQ_W    = 64;
	localparam int ROOT_W  = 32;
	localparam int P_W     = 36;
	localparam int T_W     = 36;
	localparam int R_W     = 32;
	localparam int N_COEF  = 9;

	localparam logic [LN2_W-1:0] LN2_Q28     = 28'd186065280;
	localparam logic [W_W-1:0]   W_SPLIT     = 36'h1_4000_0000;
	localparam logic [T_W-1:0]   W_CENTER    = 36'h0_A000_0000;
	localparam logic [T_W-1:0]   TAIL_OFFSET = 36'h0_C000_0000;
	localparam logic [R_W-1:0]   R_MAX       = 32'h7FFF_FFFF;
	localparam logic [R_W-1:0]   R_MIN       = 32'h8000_0000;

	typedef logic signed [P_W-1:0] coef_t;

	localparam coef_t CENTRAL_COEF [0:N_COEF-1] = '{
		36'sd30, 36'sd369, -36'sd3783, -36'sd4715, 36'sd234699, -36'sd1346177,
		-36'sd4485752, 36'sd264828464, 36'sd1612126078
	};

	localparam coef_t TAIL_COEF [0:N_COEF-1] = '{
		-36'sd214978, 36'sd108395, 36'sd1448846, -36'sd3944314, 36'sd6162750,
		-36'sd8184556, 36'sd10134910, 36'sd1075539332, 36'sd3041885700
	};

	typedef struct packed {
		logic                   neg;
		logic                   sat;
		logic signed [XS_W-1:0] xs;
	} side_t;

	typedef struct packed {
		side_t          side;
		logic [D_W-1:0] d;
	} item_t;

endpackage
`default_nettype wire

>>> design/inverse_error_function_top.sv
// inverse error function: fixed-point input, pipelined log, root and polynomial back end
// stages from accept to out_valid: the input register and the queue entry,
// then 38 + 32 + 10 back end stages ending in the output register
// throughput: one beat per cycle while out_ready stays high
// the back end pipeline advances as a whole when the output register is empty or taken
// a four-entry queue lets the front end keep accepting while the back end stalls
// reset: asynchronous, active low; clears all valid bits, queue pointers and queue count, no state otherwise
`default_nettype none
module inverse_error_function_top import ief_pkg::*; #(
	parameter int IN_FRAC_BITS  = 30,
	parameter int OUT_FRAC_BITS = 28
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic signed [X_W-1:0] x_value,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [R_W-1:0]      result_value,
	output logic                       saturated
);

	logic           en;
	logic           q_valid;
	item_t          q_item;
	logic           q_pop;
	logic           lg_valid;
	side_t          lg_side;
	logic [W_W-1:0] lg_wq;
	logic           sr_valid;
	side_t          sr_side;
	logic [W_W-1:0] sr_wq;
	logic [ROOT_W-1:0] sr_root;

	assign en    = !out_valid || out_ready;
	assign q_pop = en && q_valid;

	ief_front #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.x_value  (x_value),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	ief_log #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_log (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (q_valid),
		.item_in  (q_item),
		.v_out    (lg_valid),
		.side_out (lg_side),
		.wq_out   (lg_wq)
	);

	ief_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (lg_valid),
		.side_in  (lg_side),
		.wq_in    (lg_wq),
		.v_out    (sr_valid),
		.side_out (sr_side),
		.wq_out   (sr_wq),
		.root_out (sr_root)
	);

	ief_poly #(
		.IN_FRAC_BITS  (IN_FRAC_BITS),
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_poly (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.v_in       (sr_valid),
		.side_in    (sr_side),
		.wq_in      (sr_wq),
		.root_in    (sr_root),
		.v_out      (out_valid),
		.result_out (result_value),
		.sat_out    (saturated)
	);

endmodule
`default_nettype wire

>>> design/ief_front.sv
// front end: input register, magnitude classification and a four-entry queue
`default_nettype none
module ief_front import ief_pkg::*; #(
	parameter int IN_FRAC_BITS = 30
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic signed [X_W-1:0] x_value,
	output logic                      q_valid,
	output item_t                     q_item,
	input  wire logic                 q_pop
);

	localparam int Q_DEPTH = 4;
	localparam int PTR_W   = 2;
	localparam int CNT_W   = 3;
	localparam logic [D_W-1:0] ONE_D = D_W'(1) << (2 * IN_FRAC_BITS);

	logic [X_W:0]   u_mag;
	logic [29:0]    u_low;
	logic [59:0]    u_sq;
	item_t          cls;
	logic           f_valid_q;
	item_t          f_item_q;
	logic           q_full;
	logic           push;
	item_t          mem_q [0:Q_DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		u_mag = x_value[X_W-1] ? ((X_W+1)'(1) << X_W) - {1'b0, x_value} : {1'b0, x_value};
		u_low = u_mag[29:0];
		u_sq  = u_low * u_low;
		cls.side.neg = x_value[X_W-1];
		cls.side.sat = u_mag >= ((X_W+1)'(1) << IN_FRAC_BITS);
		// in range the raw word already is the signed value
		cls.side.xs  = x_value[XS_W-1:0];
		cls.d        = ONE_D - D_W'(u_sq);
	end

	assign q_full   = cnt_q == CNT_W'(Q_DEPTH);
	assign in_ready = !f_valid_q || !q_full;
	assign push     = f_valid_q && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_valid_q <= 1'b0;
		end else if (in_ready) begin
			f_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			f_item_q <= cls;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= f_item_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign q_valid = cnt_q != '0;
	assign q_item  = mem_q[rd_ptr_q];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(Q_DEPTH)) else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> cnt_q != '0) else $error("pop from empty queue");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push && !q_pop |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("queue count missed a push");

endmodule
`default_nettype wire

>>> design/ief_log.sv
// back end part one: normalisation, log2 by repeated squaring, scaling by ln2
`default_nettype none
module ief_log import ief_pkg::*; #(
	parameter int IN_FRAC_BITS = 30
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           v_in,
	input  wire item_t          item_in,
	output logic                v_out,
	output side_t               side_out,
	output logic [W_W-1:0]      wq_out
);

	localparam int NORM_ST = 6;

	// normalisation chain
	logic                v_n   [0:NORM_ST];
	side_t               side_n[0:NORM_ST];
	logic [NORM_W-1:0]   vec_n [0:NORM_ST];
	logic [LZ_W-1:0]     lz_n  [0:NORM_ST];

	assign v_n[0]    = v_in;
	assign side_n[0] = item_in.side;
	assign vec_n[0]  = {item_in.d, 3'b000};
	assign lz_n[0]   = '0;

	for (genvar k = 0; k < NORM_ST; k++) begin : g_norm
		localparam int SH = 32 >> k;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_n[k+1] <= 1'b0;
			end else if (en) begin
				v_n[k+1] <= v_n[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_n[k+1] <= side_n[k];
				if (vec_n[k][NORM_W-1 -: SH] == '0) begin
					vec_n[k+1] <= vec_n[k] << SH;
					lz_n[k+1]  <= lz_n[k] + LZ_W'(SH);
				end else begin
					vec_n[k+1] <= vec_n[k];
					lz_n[k+1]  <= lz_n[k];
				end
			end
		end
	end

	// one fraction bit per squaring stage
	logic              v_s   [0:FRAC_W];
	side_t             side_s[0:FRAC_W];
	logic [M_W-1:0]    m_s   [0:FRAC_W];
	logic [FRAC_W-1:0] frac_s[0:FRAC_W];
	logic [LZ_W-1:0]   lz_s  [0:FRAC_W];

	assign v_s[0]    = v_n[NORM_ST];
	assign side_s[0] = side_n[NORM_ST];
	assign m_s[0]    = vec_n[NORM_ST][NORM_W-1 -: M_W];
	assign frac_s[0] = '0;
	assign lz_s[0]   = lz_n[NORM_ST];

	for (genvar k = 0; k < FRAC_W; k++) begin : g_sq
		logic [2*M_W-1:0] sq;
		logic [M_W:0]     sh;
		assign sq = m_s[k] * m_s[k];
		assign sh = sq[2*M_W-1:M_W-1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				lz_s[k+1]   <= lz_s[k];
				if (sh[M_W]) begin
					m_s[k+1]    <= sh[M_W:1];
					frac_s[k+1] <= frac_s[k] | (FRAC_W'(1) << (FRAC_W - 1 - k));
				end else begin
					m_s[k+1]    <= sh[M_W-1:0];
					frac_s[k+1] <= frac_s[k];
				end
			end
		end
	end

	// l = 2*frac_bits - log2(d), then w = l * ln2 in two partial products
	logic [LZ_W:0]          l_int;
	logic [L_W-1:0]         l_val;
	logic                   v_w1_q;
	side_t                  side_w1_q;
	logic [17+LN2_W:0]      pl_q;
	logic [17+LN2_W:0]      ph_q;
	logic [63:0]            w_sum;

	assign l_int = (LZ_W+1)'(lz_s[FRAC_W]) + (LZ_W+1)'(2 * IN_FRAC_BITS) - (LZ_W+1)'(60);
	assign l_val = {l_int[LZ_W-1:0], {FRAC_W{1'b0}}} - L_W'(frac_s[FRAC_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_w1_q <= 1'b0;
			v_out  <= 1'b0;
		end else if (en) begin
			v_w1_q <= v_s[FRAC_W];
			v_out  <= v_w1_q;
		end
	end

	assign w_sum = {ph_q[45:0], 18'd0} + 64'(pl_q) + (64'd1 << 27);

	always_ff @(posedge clk) begin
		if (en) begin
			side_w1_q <= side_s[FRAC_W];
			pl_q      <= l_val[17:0] * LN2_Q28;
			ph_q      <= l_val[35:18] * LN2_Q28;
			side_out  <= side_w1_q;
			wq_out    <= w_sum[28 +: W_W];
		end
	end

endmodule
`default_nettype wire

>>> design/ief_sqrt.sv
// back end part two: integer square root of w, one result bit per stage
`default_nettype none
module ief_sqrt import ief_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            v_in,
	input  wire side_t           side_in,
	input  wire logic [W_W-1:0]  wq_in,
	output logic                 v_out,
	output side_t                side_out,
	output logic [W_W-1:0]       wq_out,
	output logic [ROOT_W-1:0]    root_out
);

	localparam int N_ST = SQ_W / 2;

	logic            v_s   [0:N_ST];
	side_t           side_s[0:N_ST];
	logic [W_W-1:0]  wq_s  [0:N_ST];
	logic [SQ_W-1:0] rem_s [0:N_ST];
	logic [SQ_W-1:0] root_s[0:N_ST];

	assign v_s[0]    = v_in;
	assign side_s[0] = side_in;
	assign wq_s[0]   = wq_in;
	assign rem_s[0]  = SQ_W'(wq_in) << 28;
	assign root_s[0] = '0;

	for (genvar k = 0; k < N_ST; k++) begin : g_root
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
		logic [SQ_W-1:0] trial;
		assign trial = root_s[k] + BIT;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				wq_s[k+1]   <= wq_s[k];
				if (rem_s[k] >= trial) begin
					rem_s[k+1]  <= rem_s[k] - trial;
					root_s[k+1] <= (root_s[k] >> 1) + BIT;
				end else begin
					rem_s[k+1]  <= rem_s[k];
					root_s[k+1] <= root_s[k] >> 1;
				end
			end
		end
	end

	assign v_out    = v_s[N_ST];
	assign side_out = side_s[N_ST];
	assign wq_out   = wq_s[N_ST];
	assign root_out = root_s[N_ST][ROOT_W-1:0];

endmodule
`default_nettype wire

>>> design/ief_poly.sv
// back end part three: range select, horner chain and final scaling with clamp
`default_nettype none
module ief_poly import ief_pkg::*; #(
	parameter int IN_FRAC_BITS  = 30,
	parameter int OUT_FRAC_BITS = 28
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              v_in,
	input  wire side_t             side_in,
	input  wire logic [W_W-1:0]    wq_in,
	input  wire logic [ROOT_W-1:0] root_in,
	output logic                   v_out,
	output logic signed [R_W-1:0]  result_out,
	output logic                   sat_out
);

	localparam int OUT_SH = 30 + IN_FRAC_BITS - OUT_FRAC_BITS;
	localparam int FP_W   = P_W + XS_W;
	localparam int N_ST   = N_COEF - 1;

	function automatic coef_t mul_q30(input coef_t a, input logic signed [T_W-1:0] b);
		logic                 neg;
		logic [P_W-1:0]       ua;
		logic [T_W-1:0]       ub;
		logic [P_W+T_W-1:0]   prod;
		logic [P_W+T_W-1:0]   m;
		neg  = a[P_W-1] ^ b[T_W-1];
		ua   = a[P_W-1] ? P_W'(-a) : P_W'(a);
		ub   = b[T_W-1] ? T_W'(-b) : T_W'(b);
		prod = ua * ub;
		m    = (prod + ((P_W+T_W)'(1) << 29)) >> 30;
		return neg ? -coef_t'(m[P_W-1:0]) : coef_t'(m[P_W-1:0]);
	endfunction

	logic                   v_s   [0:N_ST];
	side_t                  side_s[0:N_ST];
	logic                   tail_s[0:N_ST];
	coef_t                  p_s   [0:N_ST];
	logic signed [T_W-1:0]  t_s   [0:N_ST];

	logic                   tail_sel;
	logic signed [T_W-1:0]  t_sel;

	always_comb begin
		tail_sel = wq_in >= W_SPLIT;
		if (tail_sel) begin
			t_sel = $signed(T_W'({root_in, 1'b0}) - TAIL_OFFSET);
		end else begin
			t_sel = $signed(T_W'(wq_in) - W_CENTER);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			tail_s[0] <= tail_sel;
			t_s[0]    <= t_sel;
			p_s[0]    <= tail_sel ? TAIL_COEF[0] : CENTRAL_COEF[0];
		end
	end

	for (genvar k = 1; k <= N_ST; k++) begin : g_horner
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_s[k-1];
				tail_s[k] <= tail_s[k-1];
				t_s[k]    <= t_s[k-1];
				p_s[k]    <= (tail_s[k-1] ? TAIL_COEF[k] : CENTRAL_COEF[k])
					+ mul_q30(p_s[k-1], t_s[k-1]);
			end
		end
	end

	// p * x, rounded half away from zero, then clamped to 32 bits
	side_t           fs;
	logic            fneg;
	logic [P_W-1:0]  up;
	logic [XS_W-1:0] ux;
	logic [FP_W-1:0] fprod;
	logic [FP_W-1:0] fmag;
	logic [R_W-1:0]  res_d;
	logic            sat_d;

	always_comb begin
		fs    = side_s[N_ST];
		fneg  = p_s[N_ST][P_W-1] ^ fs.xs[XS_W-1];
		up    = p_s[N_ST][P_W-1] ? P_W'(-p_s[N_ST]) : P_W'(p_s[N_ST]);
		ux    = fs.xs[XS_W-1] ? XS_W'(-fs.xs) : XS_W'(fs.xs);
		fprod = up * ux;
		fmag  = (fprod + (FP_W'(1) << (OUT_SH - 1))) >> OUT_SH;
		priority if (fs.sat) begin
			res_d = fs.neg ? R_MIN : R_MAX;
			sat_d = 1'b1;
		end else if (!fneg && fmag > FP_W'(R_MAX)) begin
			res_d = R_MAX;
			sat_d = 1'b1;
		end else if (fneg && fmag > FP_W'(R_MIN)) begin
			res_d = R_MIN;
			sat_d = 1'b1;
		end else begin
			res_d = fneg ? R_W'(-fmag) : fmag[R_W-1:0];
			sat_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_s[N_ST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_out <= $signed(res_d);
			sat_out    <= sat_d;
		end
	end

endmodule
`default_nettype wire
